// File: rtl/dlr_pkg.sv
`timescale 1ns / 1ps

package dlr_pkg;

    localparam int OP_W        = 2;
    localparam int INDEX_W     = 11;
    localparam int VALUE_W     = 16;
    localparam int NEURON_W    = 5;
    localparam int ACT_OUT_W   = 15;
    localparam int FRAC_W      = 8;
    localparam int PROD_W      = 2 * VALUE_W;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 24;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int IN_CFG_W    = 7;
    localparam int OUT_CFG_W   = 6;

    localparam logic [IN_CFG_W-1:0]  INPUTS_RESET  = 7'd64;
    localparam logic [OUT_CFG_W-1:0] OUTPUTS_RESET = 6'd32;
    localparam logic [ACT_OUT_W-1:0] SAT_MAX       = 15'h7FFF;

    localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
    localparam logic [OP_W-1:0] OP_BIAS   = 2'd1;
    localparam logic [OP_W-1:0] OP_ACT    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_INPUTS  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUTS = 1'b1;

    // control that travels with one multiply-accumulate beat
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic zero;
    } mac_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mac_stat_t;

endpackage

// File: rtl/dlr_ram.sv
`timescale 1ns / 1ps

module dlr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/dlr_mac.sv
`timescale 1ns / 1ps

module dlr_mac #(
    parameter int ACC_W = 40
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  dlr_pkg::mac_ctl_t                    ctl_in,
    input  logic signed [dlr_pkg::VALUE_W-1:0]   act_in,
    input  logic signed [dlr_pkg::VALUE_W-1:0]   weight_in,
    input  logic signed [dlr_pkg::VALUE_W-1:0]   bias_in,
    input  logic                                 take,
    output dlr_pkg::mac_stat_t                   stat,
    output logic [dlr_pkg::ACT_OUT_W-1:0]        result
);

    import dlr_pkg::*;

    mac_ctl_t                   ctl_reg, ctl_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [VALUE_W-1:0]  bias_reg, bias_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       done_reg, done_next;

    logic signed [ACC_W-1:0]    bias_ext;
    logic signed [ACC_W-1:0]    prod_ext;

    always_comb begin
        ctl_next  = ctl_in;
        prod_next = act_in * weight_in;
        if (ctl_in.zero) begin
            prod_next = '0;
        end
        bias_next = ctl_in.first ? bias_in : bias_reg;

        // bias is Q8.8, products are Q16.16
        bias_ext = {{(ACC_W-VALUE_W-FRAC_W){bias_reg[VALUE_W-1]}}, bias_reg, {FRAC_W{1'b0}}};
        prod_ext = ACC_W'(prod_reg);

        acc_next = acc_reg;
        if (ctl_reg.valid) begin
            acc_next = ctl_reg.first ? bias_ext + prod_ext : acc_reg + prod_ext;
        end

        done_next = done_reg;
        if (take) begin
            done_next = 1'b0;
        end else if (ctl_reg.valid && ctl_reg.last) begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl_reg  <= ctl_next;
            done_reg <= done_next;
        end
        prod_reg <= prod_next;
        bias_reg <= bias_next;
        acc_reg  <= acc_next;
    end

    // relu, drop fraction bits, saturate
    always_comb begin
        if (acc_reg[ACC_W-1] || acc_reg == '0) begin
            result = '0;
        end else if (|acc_reg[ACC_W-2:FRAC_W+ACT_OUT_W]) begin
            result = SAT_MAX;
        end else begin
            result = acc_reg[FRAC_W+ACT_OUT_W-1:FRAC_W];
        end
    end

    assign stat.busy = ctl_reg.valid;
    assign stat.done = done_reg;

endmodule

// File: rtl/dense_layer_relu.sv
`timescale 1ns / 1ps

// Fully connected hidden layer with ReLU, Q8.8 in, unsigned Q7.8 out. Input
// words with s_tuser 0 or 1 write a weight (address neuron*MAX_INPUTS+element)
// or a bias, s_tuser 2 appends an activation element, and an element word with
// s_tlast set runs the layer. Load words are taken one per cycle while idle. A
// run uses one shared 16x16 multiplier and accumulator fed from the weight,
// bias and activation RAMs: each neuron issues one multiply beat per input (one
// when inputs is 0), then waits for the pipeline to drain and hand off, and
// s_tready stays low for the run, which m_tready stalls lengthen. Results
// leave in neuron order through an output register, m_tlast on the last one.
// The stores hold no reset value; read only entries that were written.

module dense_layer_relu #(
    parameter int MAX_INPUTS  = 64,
    parameter int MAX_OUTPUTS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dlr_pkg::S_DATA_W-1:0]       s_tdata,   // index[10:0], value[26:11]
    input  logic [dlr_pkg::OP_W-1:0]           s_tuser,   // op[1:0]
    input  logic                               s_tlast,   // last_element

    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dlr_pkg::M_DATA_W-1:0]       m_tdata,   // neuron[4:0], activation_out[19:5]
    output logic                               m_tlast,   // last_result

    input  logic                               cfg_we,
    input  logic [dlr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dlr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import dlr_pkg::*;

    localparam int WEIGHT_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
    localparam int WAW   = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int EW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int NW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int CW    = $clog2(MAX_INPUTS + 1);
    localparam int OW    = $clog2(MAX_OUTPUTS + 1);
    localparam int ACC_W = PROD_W + CW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [IN_CFG_W-1:0]     inputs_reg, inputs_next;
    logic [OUT_CFG_W-1:0]    outputs_reg, outputs_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [NW-1:0]           n_reg, n_next;
    logic [EW-1:0]           e_reg, e_next;
    logic [WAW-1:0]          row_reg, row_next;
    mac_ctl_t                s1_reg, s1_next;
    logic                    m_valid_reg, m_valid_next;
    logic [NEURON_W-1:0]     m_neuron_reg, m_neuron_next;
    logic [ACT_OUT_W-1:0]    m_act_reg, m_act_next;
    logic                    m_last_reg, m_last_next;

    logic [INDEX_W-1:0]        s_index;
    logic [VALUE_W-1:0]        s_value;
    logic                      s_accept;
    logic [CW-1:0]             n_in;
    logic [OW-1:0]             n_out;
    logic                      n_is_last;
    mac_ctl_t                  issue;
    logic                      take;
    logic                      pipe_empty;

    logic                      w_we, b_we, a_we;
    logic [WAW-1:0]            w_raddr;
    logic signed [VALUE_W-1:0] w_rdata, b_rdata, a_rdata;
    mac_stat_t                 mac_stat;
    logic [ACT_OUT_W-1:0]      mac_result;

    assign s_index  = s_tdata[INDEX_W-1:0];
    assign s_value  = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        n_in  = (32'(inputs_reg) > 32'(MAX_INPUTS)) ? CW'(MAX_INPUTS) : CW'(inputs_reg);
        n_out = (32'(outputs_reg) > 32'(MAX_OUTPUTS)) ? OW'(MAX_OUTPUTS) : OW'(outputs_reg);
    end

    assign n_is_last  = (OW'(n_reg) + OW'(1) == n_out);
    assign take       = mac_stat.done && (!m_valid_reg || m_tready);
    assign pipe_empty = !s1_reg.valid && !mac_stat.busy && !mac_stat.done;

    // store writes happen only while idle
    assign w_we = s_accept && (s_tuser == OP_WEIGHT) && (32'(s_index) < 32'(WEIGHT_DEPTH));
    assign b_we = s_accept && (s_tuser == OP_BIAS) && (32'(s_index) < 32'(MAX_OUTPUTS));
    assign a_we = s_accept && (s_tuser == OP_ACT) && (cnt_reg < CW'(MAX_INPUTS));
    assign w_raddr = row_reg + WAW'(e_reg);

    always_comb begin
        issue.valid = (state_reg == S_ISSUE);
        issue.first = (e_reg == '0);
        issue.zero  = (n_in == '0);
        issue.last  = issue.zero || (CW'(e_reg) + CW'(1) == n_in);
    end

    always_comb begin
        state_next    = state_reg;
        inputs_next   = inputs_reg;
        outputs_next  = outputs_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        e_next        = e_reg;
        row_next      = row_reg;
        s1_next       = issue;
        m_valid_next  = m_valid_reg;
        m_neuron_next = m_neuron_reg;
        m_act_next    = m_act_reg;
        m_last_next   = m_last_reg;

        if (cfg_we) begin
            case (cfg_index)
                REG_INPUTS:  inputs_next  = cfg_wdata[IN_CFG_W-1:0];
                REG_OUTPUTS: outputs_next = cfg_wdata[OUT_CFG_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept && s_tuser == OP_ACT) begin
                    if (s_tlast) begin
                        cnt_next = '0;
                        n_next   = '0;
                        e_next   = '0;
                        row_next = '0;
                        if (n_out != '0) begin
                            state_next = S_ISSUE;
                        end
                    end else if (cnt_reg < CW'(MAX_INPUTS)) begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            S_ISSUE: begin
                if (issue.last) begin
                    e_next     = '0;
                    state_next = S_WAIT;
                end else begin
                    e_next = e_reg + EW'(1);
                end
            end
            S_WAIT: begin
                // next neuron, or back to idle after the last, once the accumulator has handed off its result
                if (pipe_empty) begin
                    if (n_is_last) begin
                        state_next = S_IDLE;
                    end else begin
                        n_next     = n_reg + NW'(1);
                        row_next   = row_reg + WAW'(MAX_INPUTS);
                        state_next = S_ISSUE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (take) begin
            m_valid_next  = 1'b1;
            m_neuron_next = NEURON_W'(n_reg);
            m_act_next    = mac_result;
            m_last_next   = n_is_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            inputs_reg  <= INPUTS_RESET;
            outputs_reg <= OUTPUTS_RESET;
            cnt_reg     <= '0;
            n_reg       <= '0;
            e_reg       <= '0;
            row_reg     <= '0;
            s1_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            inputs_reg  <= inputs_next;
            outputs_reg <= outputs_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
            e_reg       <= e_next;
            row_reg     <= row_next;
            s1_reg      <= s1_next;
            m_valid_reg <= m_valid_next;
        end
        m_neuron_reg <= m_neuron_next;
        m_act_reg    <= m_act_next;
        m_last_reg   <= m_last_next;
    end

    dlr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (WEIGHT_DEPTH)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (WAW'(s_index)),
        .wdata (s_value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    dlr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_OUTPUTS)
    ) u_bias_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (NW'(s_index)),
        .wdata (s_value),
        .raddr (n_reg),
        .rdata (b_rdata)
    );

    dlr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_INPUTS)
    ) u_act_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (EW'(cnt_reg)),
        .wdata (s_value),
        .raddr (e_reg),
        .rdata (a_rdata)
    );

    dlr_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (s1_reg),
        .act_in    (a_rdata),
        .weight_in (w_rdata),
        .bias_in   (b_rdata),
        .take      (take),
        .stat      (mac_stat),
        .result    (mac_result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-NEURON_W-ACT_OUT_W){1'b0}}, m_act_reg, m_neuron_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/dlr_checker.sv
`timescale 1ns / 1ps

module dlr_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [dlr_pkg::OP_W-1:0]           s_tuser,
    input  logic                               s_tlast,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [dlr_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                               m_tlast
);

    import dlr_pkg::*;

    logic trigger;
    assign trigger = s_tvalid && s_tready && (s_tuser == OP_ACT) && s_tlast;

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // only the trigger element starts a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !trigger |=> s_tready)
        else $error("input stalled after a load word");

    // results are handed off only during a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while idle");

endmodule

bind dense_layer_relu dlr_checker u_dlr_checker (.*);
